@@ hdl/frmm_pkg.sv @@
// shared types, constants and coefficient table for the fir rms min/max monitor
`timescale 1ns / 1ps
`default_nettype none

package frmm_pkg;

    localparam int VOLT_W = 20;
    localparam int RMS_W  = 19;
    localparam int REF_W  = 13;
    localparam int ADC_W  = 10;
    localparam int COEF_W = 16;

    localparam logic signed [VOLT_W-1:0] VMAX       = 20'sd524287;
    localparam logic signed [VOLT_W-1:0] VMIN       = -20'sd524288;
    localparam logic signed [VOLT_W-1:0] FIVE_VOLTS = 20'sd327680;
    localparam logic [REF_W-1:0]         REF_RESET  = 13'd3000;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LATCH  = 1'b1;

    // one queued input word
    typedef struct packed {
        logic             op;
        logic [ADC_W-1:0] sample;
    } item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_FIR,
        ST_FIR_END,
        ST_SQ,
        ST_SQ_END,
        ST_ROOT_A,
        ST_ROOT_B,
        ST_RESULT
    } state_t;

    // symmetric q1.15 coefficients, zero for any tap count other than ten
    function automatic logic signed [COEF_W-1:0] coef_at(input int unsigned idx,
                                                         input int unsigned taps);
        logic signed [COEF_W-1:0] c;
        int unsigned              k;
        c = '0;
        k = (idx < 5) ? idx : 9 - idx;
        if (taps == 10 && idx < 10) begin
            case (k)
                0:       c = -16'sd1607;
                1:       c = -16'sd2289;
                2:       c = 16'sd477;
                3:       c = 16'sd6998;
                4:       c = 16'sd12805;
                default: c = '0;
            endcase
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hdl/frmm_queue.sv @@
// front end: two-word input queue that takes and stores words
`timescale 1ns / 1ps
`default_nettype none

module frmm_queue
    import frmm_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    output logic       out_valid,
    input  wire logic  out_ready,
    output item_t      out_item
);

    item_t      mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    // handshake decode
    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and fill updates
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

@@ hdl/frmm_core.sv @@
// back end: reciprocal scaling, fir mac, window squares, iterative root and peak tracking
`timescale 1ns / 1ps
`default_nettype none

module frmm_core
    import frmm_pkg::*;
#(
    parameter int TAPS           = 10,
    parameter int ADC_FULL_SCALE = 1023
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [REF_W-1:0] ref_mv,
    input  wire logic             q_valid,
    output logic                  q_ready,
    input  wire item_t            q_item,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [79:0]           m_data
);

    localparam int DEN    = ADC_FULL_SCALE * 1000;
    localparam int DEN_W  = $clog2(DEN + 1);
    localparam int HALF   = DEN / 2;
    localparam int PROD_W = ADC_W + REF_W;
    localparam int NUM_W  = 40;
    localparam int DIV_W  = NUM_W + 1;
    localparam int QW     = DIV_W - DEN_W;
    localparam int QCW    = $clog2(QW);
    // reciprocal of the denominator, scaled so the estimate is at most one low
    localparam int              RS    = 29;
    localparam longint unsigned RECIP = (64'd1 << (RS + 16)) / DEN;
    localparam int              RW    = $clog2(RECIP + 1);
    localparam int              EP_W  = PROD_W + RW;
    localparam int CW     = $clog2(TAPS);
    localparam int MP_W   = COEF_W + VOLT_W;
    localparam int ACC_W  = MP_W + 5;
    localparam int SQ_W   = 2 * VOLT_W - 1;
    localparam int SQF_W  = 2 * VOLT_W;
    localparam int SUM_W  = SQ_W + $clog2(TAPS);
    localparam int RT_W   = VOLT_W;
    localparam int RB_W   = $clog2(RT_W);
    localparam int CMP_W  = 2 * RT_W + 8;

    state_t state_reg, state_next;

    logic signed [VOLT_W-1:0] sw_reg [TAPS];
    logic signed [VOLT_W-1:0] fw_reg [TAPS];
    logic signed [VOLT_W-1:0] run_hi_reg, run_lo_reg, lat_hi_reg, lat_lo_reg;
    logic signed [VOLT_W-1:0] hi_reg, lo_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [NUM_W-1:0]         rem_reg;
    logic [QW-1:0]            quo_reg;
    logic [QCW-1:0]           dcnt_reg;
    logic [CW-1:0]            cnt_reg;
    logic signed [MP_W-1:0]   mprod_reg;
    logic                     mvld_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic                     sqvld_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [RT_W-1:0]          r_reg, t_reg;
    logic [RB_W-1:0]          rb_reg;
    logic [2*RT_W-1:0]        tsq_reg;
    logic [RMS_W-1:0]         rms_reg;
    logic                     m_valid_reg;
    logic [79:0]              m_data_reg;

    logic                     pop, out_load;
    logic [EP_W-1:0]          est_full;
    logic [NUM_W-1:0]         num_full;
    logic [NUM_W-1:0]         quo_den;
    logic [DIV_W-1:0]         trial;
    logic                     hit;
    logic [QW-1:0]            quo_next;
    logic signed [VOLT_W-1:0] volts;
    logic signed [ACC_W-1:0]  acc_total;
    logic signed [ACC_W-1:0]  acc_shift;
    logic signed [VOLT_W-1:0] filt;
    logic [RT_W-1:0]          t_try;
    logic                     root_ok;
    logic [RT_W-1:0]          r_next;
    logic [RMS_W-1:0]         rms_sat;
    logic [SQF_W-1:0]         sq_full;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = (q_item.op == OP_LATCH) ? ST_RESULT : ST_MUL;
                end
            end
            ST_MUL:     state_next = ST_PREP;
            ST_PREP:    state_next = ST_DIV;
            ST_DIV:     state_next = (dcnt_reg == '0) ? ST_FIR : ST_DIV;
            ST_FIR:     state_next = (cnt_reg == CW'(TAPS - 1)) ? ST_FIR_END : ST_FIR;
            ST_FIR_END: state_next = ST_SQ;
            ST_SQ:      state_next = (cnt_reg == CW'(TAPS - 1)) ? ST_SQ_END : ST_SQ;
            ST_SQ_END:  state_next = ST_ROOT_A;
            ST_ROOT_A:  state_next = ST_ROOT_B;
            ST_ROOT_B:  state_next = (rb_reg == '0) ? ST_RESULT : ST_ROOT_A;
            ST_RESULT:  state_next = (!m_valid_reg || m_ready) ? ST_IDLE : ST_RESULT;
            default:    state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        q_ready  = (state_reg == ST_IDLE);
        out_load = (state_reg == ST_RESULT) && (!m_valid_reg || m_ready);
    end

    assign pop = q_ready && q_valid;

    // quotient estimate by reciprocal, remainder and one-step correction
    always_comb begin
        est_full = EP_W'(prod_reg) * EP_W'(RECIP);
        num_full = NUM_W'({prod_reg, 16'b0}) + NUM_W'(HALF);
        quo_den  = NUM_W'(quo_reg) * NUM_W'(DEN);
        trial    = DIV_W'(DEN);
        hit      = ({1'b0, rem_reg} >= trial);
        quo_next = quo_reg + (hit ? QW'(1) : QW'(0));
        volts    = (32'(quo_next) > 32'(VMAX)) ? VMAX : VOLT_W'(quo_next);
    end

    // fir rounding and saturation
    always_comb begin
        acc_total = acc_reg + ACC_W'(mprod_reg);
        acc_shift = (acc_total + ACC_W'(16384)) >>> 15;
        if (acc_shift > ACC_W'(VMAX)) begin
            filt = VMAX;
        end else if (acc_shift < ACC_W'(VMIN)) begin
            filt = VMIN;
        end else begin
            filt = VOLT_W'(acc_shift);
        end
    end

    // root trial bit and acceptance
    always_comb begin
        sq_full = SQF_W'(fw_reg[cnt_reg] * fw_reg[cnt_reg]);
        t_try   = r_reg | (RT_W'(1) << rb_reg);
        root_ok = (CMP_W'(tsq_reg) * CMP_W'(TAPS)) <= CMP_W'(sum_reg);
        r_next  = root_ok ? t_reg : r_reg;
        rms_sat = (r_next > RT_W'(VMAX)) ? RMS_W'(VMAX) : RMS_W'(r_next);
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // windows, peaks and cached rms
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TAPS; i++) begin
                sw_reg[i] <= '0;
                fw_reg[i] <= '0;
            end
            run_hi_reg <= '0;
            run_lo_reg <= FIVE_VOLTS;
            lat_hi_reg <= '0;
            lat_lo_reg <= '0;
            rms_reg    <= '0;
        end else begin
            if (pop && q_item.op == OP_LATCH) begin
                lat_hi_reg <= run_hi_reg;
                lat_lo_reg <= run_lo_reg;
                run_hi_reg <= '0;
                run_lo_reg <= FIVE_VOLTS;
            end
            if (state_reg == ST_DIV && dcnt_reg == '0) begin
                for (int i = TAPS - 1; i > 0; i--) begin
                    sw_reg[i] <= sw_reg[i-1];
                end
                sw_reg[0] <= volts;
            end
            if (state_reg == ST_FIR_END) begin
                for (int i = TAPS - 1; i > 0; i--) begin
                    fw_reg[i] <= fw_reg[i-1];
                end
                fw_reg[0] <= filt;
            end
            if (state_reg == ST_SQ_END) begin
                if (run_hi_reg < hi_reg) run_hi_reg <= hi_reg;
                if (run_lo_reg > lo_reg) run_lo_reg <= lo_reg;
            end
            if (state_reg == ST_ROOT_B && rb_reg == '0) begin
                rms_reg <= rms_sat;
            end
        end
    end

    // datapath working registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                prod_reg <= PROD_W'(q_item.sample) * PROD_W'(ref_mv);
            end
            ST_MUL: begin
                quo_reg <= QW'(est_full >> RS);
            end
            ST_PREP: begin
                rem_reg  <= num_full - quo_den;
                dcnt_reg <= QCW'(1);
                cnt_reg  <= '0;
                mvld_reg <= 1'b0;
                acc_reg  <= '0;
            end
            ST_DIV: begin
                if (hit) begin
                    rem_reg <= rem_reg - NUM_W'(trial);
                end
                quo_reg  <= quo_next;
                dcnt_reg <= dcnt_reg - QCW'(1);
            end
            ST_FIR: begin
                mprod_reg <= coef_at(int'(cnt_reg), TAPS) * sw_reg[cnt_reg];
                mvld_reg  <= 1'b1;
                if (mvld_reg) begin
                    acc_reg <= acc_reg + ACC_W'(mprod_reg);
                end
                cnt_reg <= (cnt_reg == CW'(TAPS - 1)) ? '0 : cnt_reg + CW'(1);
            end
            ST_FIR_END: begin
                cnt_reg   <= '0;
                sum_reg   <= '0;
                sqvld_reg <= 1'b0;
            end
            ST_SQ: begin
                sq_reg    <= SQ_W'(sq_full);
                sqvld_reg <= 1'b1;
                if (sqvld_reg) begin
                    sum_reg <= sum_reg + SUM_W'(sq_reg);
                end
                if (cnt_reg == '0) begin
                    hi_reg <= fw_reg[0];
                    lo_reg <= fw_reg[0];
                end else begin
                    if (fw_reg[cnt_reg] > hi_reg) hi_reg <= fw_reg[cnt_reg];
                    if (fw_reg[cnt_reg] < lo_reg) lo_reg <= fw_reg[cnt_reg];
                end
                cnt_reg <= (cnt_reg == CW'(TAPS - 1)) ? '0 : cnt_reg + CW'(1);
            end
            ST_SQ_END: begin
                sum_reg <= sum_reg + SUM_W'(sq_reg);
                r_reg   <= '0;
                rb_reg  <= RB_W'(RT_W - 1);
            end
            ST_ROOT_A: begin
                t_reg   <= t_try;
                tsq_reg <= t_try * t_try;
            end
            ST_ROOT_B: begin
                r_reg  <= r_next;
                rb_reg <= rb_reg - RB_W'(1);
            end
            ST_RESULT: begin
                cnt_reg <= '0;
            end
            default: begin
                cnt_reg <= '0;
            end
        endcase
    end

    // output word: filtered, rms, max, min from the low bit up
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {1'b0, lat_lo_reg, lat_hi_reg, rms_reg, fw_reg[0]};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // running peaks stay inside their reset bounds
    a_low_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        run_lo_reg <= FIVE_VOLTS)
        else $error("running minimum above five volts");

    a_high_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        run_hi_reg >= 0)
        else $error("running maximum below zero");

    // a popped word always starts work
    a_pop_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> state_reg != ST_IDLE)
        else $error("popped word not started");

    // a result is only loaded when the output register can take it
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(m_data_reg))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

@@ hdl/fir_rms_minmax_monitor.sv @@
// Top level: input queue, processing back end and reference register.
// A sample word runs from the queue to its result load through reciprocal scaling with two
// correction steps, one mac and one square per cycle and a step through ST_ROOT_A and ST_ROOT_B per
// bit of the square root; the load waits while the output is stalled. A latch word goes straight to
// the result load. One word is worked at a time; a two-word queue accepts until full.
// aresetn (synchronous, active low) resets windows and peaks and sets the reference to 3000 mV.
`timescale 1ns / 1ps
`default_nettype none

module fir_rms_minmax_monitor
    import frmm_pkg::*;
#(
    parameter int TAPS           = 10,
    parameter int ADC_FULL_SCALE = 1023
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [12:0] cfg_data,     // reference_millivolts
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,      // adc_sample [9:0], zero fill
    input  wire logic [0:0]  s_tuser,      // op [0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata       // filtered [19:0], rms [38:20], max [58:39], min [78:59]
);

    logic [REF_W-1:0] ref_reg;
    item_t            in_item, q_item;
    logic             q_valid, q_ready;

    // reference register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_reg <= REF_RESET;
        end else if (cfg_valid) begin
            ref_reg <= cfg_data;
        end
    end

    assign in_item.op     = s_tuser[0];
    assign in_item.sample = s_tdata[ADC_W-1:0];

    frmm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    frmm_core #(
        .TAPS           (TAPS),
        .ADC_FULL_SCALE (ADC_FULL_SCALE)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ref_mv  (ref_reg),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_data  (m_tdata)
    );

endmodule

`default_nettype wire

@@ bench/fir_rms_minmax_monitor_tb.sv @@
// self-checking bench for the fir rms min/max monitor with a built-in predictor
`timescale 1ns / 1ps

module fir_rms_minmax_monitor_tb
    import frmm_pkg::*;
;

    localparam int NTAPS       = 10;
    localparam int RANDOM_WORDS = 650;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic signed [19:0] filtered;
        logic [18:0]        rms;
        logic signed [19:0] peak_max;
        logic signed [19:0] peak_min;
    } result_t;

    // directed row: op, sample, whether the result is typed in, expected result
    typedef struct {
        logic    op;
        int      sample;
        bit      typed;
        result_t want;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [12:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;

    // predictor state
    logic [12:0]        ref_mv;
    logic signed [19:0] delay_line [NTAPS];
    logic signed [19:0] filt_line [NTAPS];
    logic signed [19:0] run_high, run_low, held_high, held_low;

    result_t expected_results [$];
    int      errors = 0;
    int      cycles = 0;
    int      n_results = 0;
    int      n_latch = 0;
    int      hold_requests = 0;
    int      hold_seen = 0;
    int      hold_left = 0;
    bit      steady_out = 1'b0;
    bit      steady_in = 1'b0;
    row_t    rows [$];

    fir_rms_minmax_monitor dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic logic signed [15:0] tap_coef(int i);
        int k;
        k = (i < 5) ? i : 9 - i;
        case (k)
            0: return -16'sd1607;
            1: return -16'sd2289;
            2: return 16'sd477;
            3: return 16'sd6998;
            default: return 16'sd12805;
        endcase
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // advance the predictor by one word and queue what the block should return
    task automatic predict_monitor(input logic op, input logic [9:0] sample);
        longint unsigned num, volts, sq;
        longint          acc, fl;
        logic signed [19:0] hi, lo;
        result_t r;
        if (op == OP_SAMPLE) begin
            num = longint'(sample) * longint'(ref_mv) * 65536;
            volts = (num + 511500) / 1023000;
            for (int i = NTAPS - 1; i > 0; i--) delay_line[i] = delay_line[i-1];
            delay_line[0] = (volts > 524287) ? 20'sd524287 : 20'(volts);
            acc = 0;
            for (int i = 0; i < NTAPS; i++)
                acc += longint'(tap_coef(i)) * longint'(delay_line[i]);
            acc += 16384;
            fl = (acc >= 0) ? (acc >>> 15) : -((-acc + 32767) >>> 15);
            for (int i = NTAPS - 1; i > 0; i--) filt_line[i] = filt_line[i-1];
            filt_line[0] = (fl > 524287) ? 20'sd524287 :
                           (fl < -524288) ? -20'sd524288 : 20'(fl);
            hi = filt_line[0];
            lo = filt_line[0];
            for (int i = 1; i < NTAPS; i++) begin
                if (filt_line[i] > hi) hi = filt_line[i];
                if (filt_line[i] < lo) lo = filt_line[i];
            end
            if (run_high < hi) run_high = hi;
            if (run_low > lo) run_low = lo;
        end else begin
            held_high = run_high;
            held_low = run_low;
            run_high = '0;
            run_low = FIVE_VOLTS;
        end
        sq = 0;
        for (int i = 0; i < NTAPS; i++)
            sq += longint'(filt_line[i]) * longint'(filt_line[i]);
        sq = int_sqrt(sq / NTAPS);
        r.filtered = filt_line[0];
        r.rms = (sq > 524287) ? 19'd524287 : 19'(sq);
        r.peak_max = held_high;
        r.peak_min = held_low;
        expected_results.push_back(r);
    endtask

    // typed table values against the predictor, field by field
    task automatic check_row(input result_t want, input result_t pred);
        if (want.filtered !== pred.filtered) begin
            errors++;
            $error("table filtered_volts expected %0d actual %0d", want.filtered, pred.filtered);
        end
        if (want.rms !== pred.rms) begin
            errors++;
            $error("table rms_volts expected %0d actual %0d", want.rms, pred.rms);
        end
        if (want.peak_max !== pred.peak_max) begin
            errors++;
            $error("table reported_max expected %0d actual %0d", want.peak_max, pred.peak_max);
        end
        if (want.peak_min !== pred.peak_min) begin
            errors++;
            $error("table reported_min expected %0d actual %0d", want.peak_min, pred.peak_min);
        end
    endtask

    // random pause with the input dropped
    task automatic idle_gap();
        if (!steady_in && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // offer one word and hold it until accepted; checked rows pass their result
    task automatic send_word(input logic op, input logic [9:0] sample,
                             input bit typed, input result_t want);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {6'd0, sample};
        do @(posedge aclk); while (!s_tready);
        predict_monitor(op, sample);
        if (typed) check_row(want, expected_results[$]);
        if (op == OP_LATCH) n_latch++;
        idle_gap();
    endtask

    task automatic write_reference(input logic [12:0] mv);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= mv;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        ref_mv = mv;
    endtask

    task automatic random_words(input int count);
        for (int i = 0; i < count; i++)
            send_word(($urandom_range(99) < 12) ? OP_LATCH : OP_SAMPLE,
                      ($urandom_range(9) == 0) ? (($urandom_range(1)) ? 10'h3ff : 10'h0)
                                               : 10'($urandom),
                      1'b0, '0);
        s_tvalid <= 1'b0;
    endtask

    // receiver: random stalls, plus a long hold-off counted here on request
    always @(posedge aclk) begin
        if (hold_requests != hold_seen) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady_out || ($urandom_range(99) >= 34);
        end
    end

    // result checker
    always @(posedge aclk) begin
        result_t got, exp_r;
        cycles++;
        if (aresetn && m_tvalid && m_tready) begin
            got.filtered = m_tdata[19:0];
            got.rms = m_tdata[38:20];
            got.peak_max = m_tdata[58:39];
            got.peak_min = m_tdata[78:59];
            n_results++;
            if (expected_results.size() == 0) begin
                errors++;
                $error("result word with nothing expected: %h", m_tdata);
            end else begin
                exp_r = expected_results.pop_front();
                if (got.filtered !== exp_r.filtered) begin
                    errors++;
                    $error("filtered_volts expected %0d actual %0d", exp_r.filtered, got.filtered);
                end
                if (got.rms !== exp_r.rms) begin
                    errors++;
                    $error("rms_volts expected %0d actual %0d", exp_r.rms, got.rms);
                end
                if (got.peak_max !== exp_r.peak_max) begin
                    errors++;
                    $error("reported_max expected %0d actual %0d", exp_r.peak_max, got.peak_max);
                end
                if (got.peak_min !== exp_r.peak_min) begin
                    errors++;
                    $error("reported_min expected %0d actual %0d", exp_r.peak_min, got.peak_min);
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        row_t    rw;
        result_t z;
        ref_mv = REF_RESET;
        for (int i = 0; i < NTAPS; i++) begin
            delay_line[i] = '0;
            filt_line[i] = '0;
        end
        run_high = '0;
        run_low = FIVE_VOLTS;
        held_high = '0;
        held_low = '0;

        // directed table: typed rows read straight off the reset state
        z = '0;
        rows.push_back('{OP_LATCH, 0, 1'b1, '{20'sd0, 19'd0, 20'sd0, 20'sd327680}});
        rows.push_back('{OP_LATCH, 0, 1'b1, '{20'sd0, 19'd0, 20'sd0, 20'sd327680}});
        rows.push_back('{OP_SAMPLE, 0, 1'b1, '{20'sd0, 19'd0, 20'sd0, 20'sd327680}});
        for (int i = 0; i < 12; i++) rows.push_back('{OP_SAMPLE, 1023, 1'b0, z});
        rows.push_back('{OP_LATCH, 0, 1'b0, z});
        rows.push_back('{OP_SAMPLE, 512, 1'b0, z});
        rows.push_back('{OP_SAMPLE, 1, 1'b0, z});
        for (int i = 0; i < 4; i++) rows.push_back('{OP_SAMPLE, 0, 1'b0, z});
        rows.push_back('{OP_LATCH, 1023, 1'b0, z});

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        steady_out = 1'b1;
        steady_in = 1'b1;
        foreach (rows[i]) begin
            rw = rows[i];
            send_word(rw.op, 10'(rw.sample), rw.typed, rw.want);
        end
        s_tvalid <= 1'b0;
        steady_out = 1'b0;
        steady_in = 1'b0;

        // reference sweep, extremes included, random words at each setting
        write_reference(13'd5000);
        random_words(130);
        write_reference(13'd1);
        random_words(80);
        write_reference(13'd8191);
        random_words(80);
        write_reference(13'd0);
        random_words(40);

        // receiver holds off while the sender keeps offering, so the input stalls
        write_reference(13'($urandom_range(1, 5000)));
        hold_requests++;
        random_words(60);
        while (expected_results.size() != 0) @(posedge aclk);
        random_words(130);

        // no random idling on either side for a while
        steady_out = 1'b1;
        steady_in = 1'b1;
        random_words(70);
        steady_out = 1'b0;
        steady_in = 1'b0;
        write_reference(REF_RESET);
        random_words(60);

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("checked %0d result words, %0d latch words, across six reference settings",
                 n_results, n_latch);
        $display("including reference extremes, output back-pressure and input stalls");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
